FILE: src/gcbc_pkg.sv
// Package for the graph connectivity / bipartite checker.
// Shared constants, item codes and the result record type.
// No dependencies.
`default_nettype none

package gcbc_pkg;

    // Default sizing of the graph storage
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    // Field widths fixed by the interface
    localparam int VCOUNT_W     = 11;
    localparam int ENDPOINT_W   = 10;
    localparam int QUEUE_DEPTH  = 4;

    // Reset value of the vertex count register
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(1);

    // Item opcodes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    // One evaluation result
    typedef struct packed {
        logic connected;
        logic bipartite_component;
        logic answer_yes;
        logic overflow;
    } res_t;

endpackage

`default_nettype wire

FILE: src/gcbc_front.sv
// Front end: accepts items and classifies them before queueing.
// Edges with an endpoint outside the vertex storage are dropped here.
// Depends on gcbc_pkg.
`default_nettype none

module gcbc_front #(
    parameter int MAX_VERTICES = gcbc_pkg::DEF_MAX_VERTICES,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  wire logic                            push,
    input  wire logic                            full,
    input  wire logic                            opcode,
    input  wire logic [gcbc_pkg::ENDPOINT_W-1:0] end_a,
    input  wire logic [gcbc_pkg::ENDPOINT_W-1:0] end_b,
    output logic                                 q_push,
    output logic [2*VW:0]                        q_data
);
    import gcbc_pkg::*;

    logic in_range;
    logic keep;

    // Endpoints must address an existing adjacency list
    assign in_range = (32'(end_a) < 32'(MAX_VERTICES)) && (32'(end_b) < 32'(MAX_VERTICES));
    assign keep     = (opcode == OP_EVALUATE) || in_range;

    assign q_push = push && !full && keep;
    assign q_data = {opcode, VW'(end_a), VW'(end_b)};

endmodule

`default_nettype wire

FILE: src/gcbc_queue.sv
// Short command queue between the front end and the execution engine.
// Register based circular buffer of QUEUE_DEPTH entries.
// Depends on gcbc_pkg.
`default_nettype none

module gcbc_queue #(
    parameter int WIDTH = 21
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  full,
    output logic                  empty
);
    import gcbc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/gcbc_engine.sv
// Execution engine: adjacency list storage, depth-first two-coloring walk,
// result register and the clearing sweep. Holds the vertex count register.
// Depends on gcbc_pkg.
`default_nettype none

module gcbc_engine #(
    parameter int MAX_VERTICES = gcbc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gcbc_pkg::DEF_MAX_EDGES,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gcbc_pkg::VCOUNT_W-1:0] cfg_wr_data,
    input  wire logic                          q_empty,
    input  wire logic [2*VW:0]                 q_data,
    output logic                               q_pop,
    output logic                               res_valid,
    output gcbc_pkg::res_t                     res,
    input  wire logic                          res_pop
);
    import gcbc_pkg::*;

    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = SW + 1;
    localparam logic [PW-1:0] NO_LINK = {PW{1'b1}};
    localparam logic [VW-1:0] LAST_V  = VW'(MAX_VERTICES - 1);

    localparam logic [1:0] COLOR_NONE = 2'd0;
    localparam logic [1:0] COLOR_A    = 2'd1;
    localparam logic [1:0] COLOR_B    = 2'd2;

    // Sequencer states
    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_EDGE_A = 4'd2;
    localparam logic [3:0] ST_EDGE_B = 4'd3;
    localparam logic [3:0] ST_K_READ = 4'd4;
    localparam logic [3:0] ST_K_CHK  = 4'd5;
    localparam logic [3:0] ST_POP    = 4'd6;
    localparam logic [3:0] ST_POP2   = 4'd7;
    localparam logic [3:0] ST_HEAD   = 4'd8;
    localparam logic [3:0] ST_SCAN   = 4'd9;
    localparam logic [3:0] ST_TGT    = 4'd10;
    localparam logic [3:0] ST_COLOR  = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    // Memories
    logic [PW-1:0] head_mem  [MAX_VERTICES];
    logic [1:0]    color_mem [MAX_VERTICES];
    logic [VW-1:0] stack_mem [MAX_VERTICES];
    logic [VW-1:0] tgt_mem   [SLOTS];
    logic [PW-1:0] next_mem  [SLOTS];

    logic [PW-1:0] head_rd_reg;
    logic [1:0]    color_rd_reg;
    logic [VW-1:0] stack_rd_reg;
    logic [VW-1:0] tgt_rd_reg;
    logic [PW-1:0] next_rd_reg;

    // Memory port controls
    logic          head_we;
    logic [VW-1:0] head_waddr, head_raddr;
    logic [PW-1:0] head_wdata;
    logic          color_we;
    logic [VW-1:0] color_waddr, color_raddr;
    logic [1:0]    color_wdata;
    logic          stack_we;
    logic [VW-1:0] stack_waddr, stack_raddr;
    logic [VW-1:0] stack_wdata;
    logic          link_we;
    logic [SW-1:0] link_waddr, link_raddr;
    logic [VW-1:0] tgt_wdata;
    logic [PW-1:0] next_wdata;

    // Control state
    logic [3:0]          state_reg, state_next;
    logic [VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [PW-1:0]       slots_reg, slots_next;
    logic                drop_reg, drop_next;
    logic [VW-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       depth_reg, depth_next;
    logic [CW-1:0]       size_reg, size_next;
    logic                ok_reg, ok_next;
    logic                conn_reg, conn_next;
    logic                bip_reg, bip_next;
    logic [1:0]          cur_reg, cur_next;
    logic [PW-1:0]       s_reg, s_next;
    logic [VW-1:0]       w_reg, w_next;
    logic [VW-1:0]       a_reg, a_next;
    logic [VW-1:0]       b_reg, b_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic          q_op;
    logic [VW-1:0] q_a, q_b;
    logic [31:0]   n_clamp;
    logic [CW-1:0] depth_m1;
    logic [PW-1:0] slot_b;

    assign q_op     = q_data[2*VW];
    assign q_a      = q_data[2*VW-1:VW];
    assign q_b      = q_data[VW-1:0];
    assign depth_m1 = depth_reg - 1'b1;
    assign slot_b   = slots_reg + 1'b1;

    // Vertex count clamped into 1 .. MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_clamp = 32'd1;
        end
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            n_clamp = 32'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = 32'(vcount_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = cfg_wr_en ? cfg_wr_data : vcount_reg;
        slots_next     = slots_reg;
        drop_next      = drop_reg;
        clr_next       = clr_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        depth_next     = depth_reg;
        size_next      = size_reg;
        ok_next        = ok_reg;
        conn_next      = conn_reg;
        bip_next       = bip_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        q_pop          = 1'b0;

        head_we     = 1'b0;
        head_waddr  = a_reg;
        head_wdata  = slots_reg;
        head_raddr  = a_reg;
        color_we    = 1'b0;
        color_waddr = w_reg;
        color_wdata = COLOR_NONE;
        color_raddr = w_reg;
        stack_we    = 1'b0;
        stack_waddr = depth_reg[VW-1:0];
        stack_wdata = w_reg;
        stack_raddr = depth_m1[VW-1:0];
        link_we     = 1'b0;
        link_waddr  = slots_reg[SW-1:0];
        link_raddr  = s_reg[SW-1:0];
        tgt_wdata   = b_reg;
        next_wdata  = head_rd_reg;

        case (state_reg)
            // Empty every list and uncolor every vertex
            ST_CLEAR:
            begin
                head_we     = 1'b1;
                head_waddr  = clr_reg;
                head_wdata  = NO_LINK;
                color_we    = 1'b1;
                color_waddr = clr_reg;
                color_wdata = COLOR_NONE;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_V)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // Take the next queued item
            ST_IDLE:
            begin
                head_raddr = q_a;
                if (!q_empty)
                begin
                    q_pop   = 1'b1;
                    a_next  = q_a;
                    b_next  = q_b;
                    if (q_op == OP_EVALUATE)
                    begin
                        n_next     = CW'(n_clamp);
                        k_next     = '0;
                        conn_next  = 1'b0;
                        bip_next   = 1'b0;
                        state_next = ST_K_READ;
                    end
                    else if (32'(slots_reg) + 32'd2 > 32'(SLOTS))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EDGE_A;
                    end
                end
            end

            // Link b into the list of a, fetch the head of b
            ST_EDGE_A:
            begin
                link_we    = 1'b1;
                link_waddr = slots_reg[SW-1:0];
                tgt_wdata  = b_reg;
                next_wdata = head_rd_reg;
                head_we    = 1'b1;
                head_waddr = a_reg;
                head_wdata = slots_reg;
                head_raddr = b_reg;
                state_next = ST_EDGE_B;
            end

            // Link a into the list of b; a self-loop sees its own new head
            ST_EDGE_B:
            begin
                link_we    = 1'b1;
                link_waddr = slot_b[SW-1:0];
                tgt_wdata  = a_reg;
                next_wdata = (a_reg == b_reg) ? slots_reg : head_rd_reg;
                head_we    = 1'b1;
                head_waddr = b_reg;
                head_wdata = slot_b;
                slots_next = slots_reg + PW'(2);
                state_next = ST_IDLE;
            end

            // Outer scan over vertices
            ST_K_READ:
            begin
                color_raddr = k_reg[VW-1:0];
                if (k_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_K_CHK;
                end
            end

            // Start a new component at an uncolored vertex
            ST_K_CHK:
            begin
                if (color_rd_reg != COLOR_NONE)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_K_READ;
                end
                else
                begin
                    color_we    = 1'b1;
                    color_waddr = k_reg[VW-1:0];
                    color_wdata = COLOR_A;
                    stack_we    = 1'b1;
                    stack_waddr = '0;
                    stack_wdata = k_reg[VW-1:0];
                    depth_next  = CW'(1);
                    ok_next     = 1'b1;
                    size_next   = '0;
                    state_next  = ST_POP;
                end
            end

            // Pop a vertex, or close the component when the stack is empty
            ST_POP:
            begin
                stack_raddr = depth_m1[VW-1:0];
                if (depth_reg == '0)
                begin
                    if (k_reg == '0)
                    begin
                        conn_next = (size_reg == n_reg);
                    end
                    if (ok_reg && (size_reg > CW'(1)))
                    begin
                        bip_next = 1'b1;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = ST_K_READ;
                end
                else
                begin
                    depth_next = depth_m1;
                    state_next = ST_POP2;
                end
            end

            // Fetch head and color of the popped vertex
            ST_POP2:
            begin
                head_raddr  = stack_rd_reg;
                color_raddr = stack_rd_reg;
                size_next   = size_reg + 1'b1;
                state_next  = ST_HEAD;
            end

            ST_HEAD:
            begin
                cur_next   = color_rd_reg;
                s_next     = head_rd_reg;
                state_next = ST_SCAN;
            end

            // Walk the adjacency list
            ST_SCAN:
            begin
                link_raddr = s_reg[SW-1:0];
                if (s_reg < slots_reg)
                begin
                    state_next = ST_TGT;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            // Neighbors beyond the vertex count are skipped
            ST_TGT:
            begin
                w_next      = tgt_rd_reg;
                s_next      = next_rd_reg;
                color_raddr = tgt_rd_reg;
                if (CW'(tgt_rd_reg) < n_reg)
                begin
                    state_next = ST_COLOR;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            // Color and push a new neighbor, or check for a conflict
            ST_COLOR:
            begin
                if (color_rd_reg == COLOR_NONE)
                begin
                    color_we    = 1'b1;
                    color_waddr = w_reg;
                    color_wdata = (cur_reg == COLOR_A) ? COLOR_B : COLOR_A;
                    if (32'(depth_reg) < 32'(MAX_VERTICES))
                    begin
                        stack_we    = 1'b1;
                        stack_waddr = depth_reg[VW-1:0];
                        stack_wdata = w_reg;
                        depth_next  = depth_reg + 1'b1;
                    end
                end
                else if (color_rd_reg == cur_reg)
                begin
                    ok_next = 1'b0;
                end
                state_next = ST_SCAN;
            end

            // Hand the result over, then clear the graph
            ST_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next               = 1'b1;
                    res_next.connected           = conn_reg;
                    res_next.bipartite_component = bip_reg;
                    res_next.answer_yes          = !conn_reg && bip_reg;
                    res_next.overflow            = drop_reg;
                    slots_next                   = '0;
                    drop_next                    = 1'b0;
                    clr_next                     = '0;
                    state_next                   = ST_CLEAR;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            vcount_reg    <= VCOUNT_RESET;
            slots_reg     <= '0;
            drop_reg      <= 1'b0;
            clr_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            depth_reg     <= '0;
            size_reg      <= '0;
            ok_reg        <= 1'b0;
            conn_reg      <= 1'b0;
            bip_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            slots_reg     <= slots_next;
            drop_reg      <= drop_next;
            clr_reg       <= clr_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            depth_reg     <= depth_next;
            size_reg      <= size_next;
            ok_reg        <= ok_next;
            conn_reg      <= conn_next;
            bip_reg       <= bip_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        s_reg   <= s_next;
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    // Adjacency list heads
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[head_raddr];
    end

    // Vertex colors
    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        color_rd_reg <= color_mem[color_raddr];
    end

    // Walk stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    // Link slots: target vertex and next slot
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            tgt_mem[link_waddr]  <= tgt_wdata;
            next_mem[link_waddr] <= next_wdata;
        end
        tgt_rd_reg  <= tgt_mem[link_raddr];
        next_rd_reg <= next_mem[link_raddr];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: src/graph_connectivity_bipartite_check.sv
// Top level of the graph connectivity / bipartite checker.
// Instantiates gcbc_front, gcbc_queue and gcbc_engine; depends on gcbc_pkg.
//
// Usage:
//   Input queue: an item (opcode, end_a, end_b) is taken when push is high and
//   full is low. opcode OP_ADD_EDGE stores an undirected edge; OP_EVALUATE
//   walks the graph, produces one result and clears the graph.
//   Result queue: while empty is low the result sits on the output ports and
//   is taken when pop is high. The four-entry command queue keeps taking
//   items while the engine works; full goes high once it holds four.
//   Config: cfg_wr_en writes cfg_wr_data into vertex_count; the user must write it only while idle (not enforced).
// Operation (one item at a time in the engine):
//   Edge add: pop with head read, then two link writes.
//   Evaluate: scans the first n vertices (n the clamped vertex count), walks
//   each new component through its list entries, one memory access per step,
//   then a clearing sweep over all MAX_VERTICES head and color memory entries.
//   Once the walk ends and the output is free, ST_DONE registers the result.
// Reset: rst_n clears the queues and starts the clearing sweep over all
//   MAX_VERTICES entries; items queue up meanwhile and run after it.
// Stall: if the result is not popped, the engine holds the next finished
//   evaluation until it is; items queued behind it wait.
`default_nettype none

module graph_connectivity_bipartite_check #(
    parameter int MAX_VERTICES = gcbc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = gcbc_pkg::DEF_MAX_EDGES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gcbc_pkg::VCOUNT_W-1:0]   cfg_wr_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            opcode,
    input  wire logic [gcbc_pkg::ENDPOINT_W-1:0] end_a,
    input  wire logic [gcbc_pkg::ENDPOINT_W-1:0] end_b,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 connected,
    output logic                                 bipartite_component,
    output logic                                 answer_yes,
    output logic                                 overflow
);
    import gcbc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    logic          q_push, q_pop, q_empty;
    logic [2*VW:0] q_wdata, q_rdata;
    logic          res_valid;
    res_t          res;

    gcbc_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_front (
        .push   (push),
        .full   (full),
        .opcode (opcode),
        .end_a  (end_a),
        .end_b  (end_b),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    gcbc_queue #(
        .WIDTH (2*VW + 1)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .full    (full),
        .empty   (q_empty)
    );

    gcbc_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VW           (VW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res         (res),
        .res_pop     (pop)
    );

    assign empty               = !res_valid;
    assign connected           = res.connected;
    assign bipartite_component = res.bipartite_component;
    assign answer_yes          = res.answer_yes;
    assign overflow            = res.overflow;

endmodule

`default_nettype wire

FILE: src/gcbc_checker.sv
// Port-level checks for graph_connectivity_bipartite_check.
// Attached to the top level by the bind statement at the end of this file.
// Depends on nothing else.
`default_nettype none

module gcbc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic empty,
    input wire logic pop,
    input wire logic connected,
    input wire logic bipartite_component,
    input wire logic answer_yes,
    input wire logic overflow
);

    // No result is offered once reset has been seen
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered during reset");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({connected, bipartite_component,
                                                  answer_yes, overflow})))
        else $error("waiting result changed");

    // The answer flag follows from the other two
    a_answer_rule: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (answer_yes == (!connected && bipartite_component)))
        else $error("answer flag inconsistent");

    // Results are single-buffered: a taken result leaves the port empty
    a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("result present right after a pop");

endmodule

bind graph_connectivity_bipartite_check gcbc_checker u_gcbc_checker (.*);

`default_nettype wire
